FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/sacte_pkg.sv
// ----------------------------------------------------------------------------
// sacte_pkg
// Shared geometry, types and widths of the cache tag engine.
// ----------------------------------------------------------------------------
package sacte_pkg;

    // geometry, each a power of two
    localparam int SET_COUNT  = 128;
    localparam int WAY_COUNT  = 8;
    localparam int LINE_BYTES = 64;

    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 3;
    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int SET_W     = $clog2(SET_COUNT);
    localparam int LINE_W    = ADDR_W - OFF_W;
    localparam int TAG_W     = LINE_W - SET_W;
    localparam int WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

    localparam int OUT_WAY_W  = 3;
    localparam int OUT_LINE_W = 26;

    localparam int              LFSR_W     = 16;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 16'hACE1;

    // access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [WAY_W-1:0] t_way;

    // one memory row holds a whole set
    typedef struct packed {
        logic [WAY_COUNT-1:0] valid;
        t_tag [WAY_COUNT-1:0] tag;
    } t_row;

    typedef struct packed {
        logic hit;
        t_way hit_way;
        logic has_free;
        t_way free_way;
    } t_way_info;

endpackage

FILE: rtl/core/sacte_tag_ram.sv
// ----------------------------------------------------------------------------
// sacte_tag_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sacte_tag_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/sacte_way_select.sv
// ----------------------------------------------------------------------------
// sacte_way_select
// Tag compare across the ways of one set, plus lowest free way search.
// ----------------------------------------------------------------------------
module sacte_way_select (
    input  sacte_pkg::t_row      i_row,
    input  sacte_pkg::t_tag      i_tag,
    output sacte_pkg::t_way_info o_info
);

    import sacte_pkg::*;

    always_comb begin
        o_info = '0;
        // walk downwards so the lowest way wins
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (i_row.valid[w] && (i_row.tag[w] == i_tag)) begin
                o_info.hit     = 1'b1;
                o_info.hit_way = WAY_W'(w);
            end
            if (!i_row.valid[w]) begin
                o_info.has_free = 1'b1;
                o_info.free_way = WAY_W'(w);
            end
        end
    end

endmodule

FILE: rtl/core/sacte_victim.sv
// ----------------------------------------------------------------------------
// sacte_victim
// Replacement lfsr and the random victim way taken from its next value.
// ----------------------------------------------------------------------------
module sacte_victim (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    output sacte_pkg::t_way o_way
);

    import sacte_pkg::*;

    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] n_lfsr;

    // taps 16,14,13,11, shifting right
    assign n_lfsr = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[LFSR_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_RESET;
        end else if (i_advance) begin
            r_lfsr <= n_lfsr;
        end
    end

    // way count is a power of two, so the remainder is just the low bits
    assign o_way = WAY_W'(n_lfsr % LFSR_W'(WAY_COUNT));

endmodule

FILE: rtl/core/set_assoc_cache_tag_engine.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_engine
// Tag lookup and read-miss allocation for an 8-way write-through cache.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. Most accesses go
// through the first look state only before busy falls again: the accept
// cycle reads the set row from the tag RAM and the following cycle compares
// and, on an allocation, writes the row back. A line-crossing access that
// needs the following line looked up also goes through the second look state,
// since the single read port of the tag RAM serves that lookup on its own.
// After reset busy stays high while the tag RAM is cleared one set per cycle.
// Each result is shown for one cycle with o_valid high and cannot be held
// off; the next access may be accepted in that same cycle.
module set_assoc_cache_tag_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic [sacte_pkg::ADDR_W-1:0]         i_address,
    input  logic [sacte_pkg::LEN_W-1:0]          i_length,
    output logic                                 o_valid,
    output logic                                 o_first_hit,
    output logic [sacte_pkg::OUT_WAY_W-1:0]      o_first_way,
    output logic                                 o_crosses_line,
    output logic                                 o_second_looked_up,
    output logic                                 o_second_hit,
    output logic                                 o_fill_done,
    output logic [sacte_pkg::OUT_WAY_W-1:0]      o_fill_way,
    output logic [sacte_pkg::OUT_LINE_W-1:0]     o_fill_line_address,
    output logic                                 o_evicted_valid
);

    import sacte_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK1 = 2'd2;
    localparam logic [1:0] S_LOOK2 = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [SET_W-1:0] r_clr_idx, n_clr_idx;
    logic             r_mode;
    logic [LINE_W-1:0] r_line;
    logic             r_cross;
    logic             r_first_hit;
    t_way             r_first_way;

    logic              acc;
    logic [LINE_W-1:0] acc_line;
    logic [OFF_W-1:0]  acc_off;
    logic              acc_cross;
    logic [LINE_W-1:0] nxt_line;
    logic [LINE_W-1:0] cur_line;
    t_tag              cur_tag;
    logic [SET_W-1:0]  cur_set;

    t_row      rd_row;
    t_row      wr_row;
    t_way_info info;
    t_way      victim_way;
    t_way      alloc_way;

    logic do_emit, do_alloc, go_look2;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    t_row             ram_wdata;

    assign busy = (r_state != S_IDLE);
    assign acc  = start && (r_state == S_IDLE);

    assign acc_line  = i_address[ADDR_W-1:OFF_W];
    assign acc_off   = i_address[OFF_W-1:0];
    assign acc_cross = ({1'b0, acc_off} + (OFF_W+1)'(i_length)) > (OFF_W+1)'(LINE_BYTES);

    // following line wraps to zero at the top of the address space
    assign nxt_line = r_line + LINE_W'(1);
    assign cur_line = (r_state == S_LOOK2) ? nxt_line : r_line;
    assign cur_tag  = cur_line[LINE_W-1:SET_W];
    assign cur_set  = cur_line[SET_W-1:0];

    sacte_tag_ram #(
        .DATA_W ($bits(t_row)),
        .DEPTH  (SET_COUNT)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_row)
    );

    sacte_way_select u_way_select (
        .i_row  (rd_row),
        .i_tag  (cur_tag),
        .o_info (info)
    );

    sacte_victim u_victim (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (do_alloc && !info.has_free),
        .o_way     (victim_way)
    );

    always_comb begin
        do_emit  = 1'b0;
        do_alloc = 1'b0;
        go_look2 = 1'b0;
        case (r_state)
            S_LOOK1: begin
                if ((r_mode == MODE_WRITE) || info.hit) begin
                    if (r_cross) begin
                        go_look2 = 1'b1;
                    end else begin
                        do_emit = 1'b1;
                    end
                end else begin
                    do_alloc = 1'b1;
                    do_emit  = 1'b1;
                end
            end
            S_LOOK2: begin
                do_emit  = 1'b1;
                do_alloc = (r_mode == MODE_READ) && !info.hit;
            end
            default: ;
        endcase
    end

    assign alloc_way = info.has_free ? info.free_way : victim_way;

    always_comb begin
        wr_row                  = rd_row;
        wr_row.valid[alloc_way] = 1'b1;
        wr_row.tag[alloc_way]   = cur_tag;
    end

    // writes happen only in a look cycle or the clear pass, never beside a
    // read of the same row, so no forwarding is needed
    assign ram_we    = (r_state == S_CLEAR) || do_alloc;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_idx : cur_set;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : wr_row;
    assign ram_re    = acc || go_look2;
    assign ram_raddr = (r_state == S_IDLE) ? acc_line[SET_W-1:0] : nxt_line[SET_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + SET_W'(1);
                if (r_clr_idx == SET_W'(SET_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_state = S_LOOK1;
                end
            end
            S_LOOK1: begin
                n_state = go_look2 ? S_LOOK2 : S_IDLE;
            end
            S_LOOK2: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            o_valid   <= do_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mode  <= i_mode;
            r_line  <= acc_line;
            r_cross <= acc_cross;
        end
        if (r_state == S_LOOK1) begin
            r_first_hit <= info.hit;
            r_first_way <= info.hit_way;
        end
        if (do_emit) begin
            o_first_hit         <= (r_state == S_LOOK1) ? info.hit : r_first_hit;
            o_first_way         <= OUT_WAY_W'((r_state == S_LOOK1) ? info.hit_way
                                                                   : r_first_way);
            o_crosses_line      <= r_cross;
            o_second_looked_up  <= (r_state == S_LOOK2);
            o_second_hit        <= (r_state == S_LOOK2) && info.hit;
            o_fill_done         <= do_alloc;
            o_fill_way          <= do_alloc ? OUT_WAY_W'(alloc_way) : '0;
            o_fill_line_address <= do_alloc ? OUT_LINE_W'(cur_line) : '0;
            o_evicted_valid     <= do_alloc && !info.has_free;
        end
    end

    `ASSERT_IMPLIES(a_valid_after_look, i_clk, i_rst_n, o_valid, $past(r_state) == S_LOOK1 || $past(r_state) == S_LOOK2)
    `ASSERT_IMPLIES(a_no_write_alloc, i_clk, i_rst_n, o_valid && o_fill_done, r_mode == MODE_READ)
    `ASSERT_IMPLIES(a_second_needs_cross, i_clk, i_rst_n, o_valid && o_second_looked_up, o_crosses_line && (o_first_hit || r_mode == MODE_WRITE))
    `ASSERT_NEXT(a_alloc_returns_idle, i_clk, i_rst_n, do_alloc, r_state == S_IDLE)

endmodule

FILE: verif/tb_set_assoc_cache_tag_engine.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_engine
// Self-checking bench for the cache tag engine. A table of directed accesses
// (hits, misses, line crossings, wrap at the top of memory, odd lengths,
// a full set forcing random eviction) is followed by random accesses that
// mostly land on a few busy sets and on lines seen before. Each result beat
// is checked field by field against the table's result where one is given,
// else against an in-bench model of the tags, valid bits and victim LFSR.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_engine;

    import sacte_pkg::*;

    localparam int ENTRIES     = SET_COUNT * WAY_COUNT;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 16;
    localparam int PHASE_ITEMS = 500;
    localparam int HISTORY_MAX = 64;

    typedef struct packed {
        logic                  first_hit;
        logic [OUT_WAY_W-1:0]  first_way;
        logic                  crosses_line;
        logic                  second_looked_up;
        logic                  second_hit;
        logic                  fill_done;
        logic [OUT_WAY_W-1:0]  fill_way;
        logic [OUT_LINE_W-1:0] fill_line_address;
        logic                  evicted_valid;
    } t_lookup_result;

    typedef struct {
        bit             mode;
        logic [31:0]    address;
        logic [2:0]     length;
        bit             known;
        t_lookup_result result;
    } t_access_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_mode;
    logic [ADDR_W-1:0]     i_address;
    logic [LEN_W-1:0]      i_length;
    logic                  o_valid;
    logic                  o_first_hit;
    logic [OUT_WAY_W-1:0]  o_first_way;
    logic                  o_crosses_line;
    logic                  o_second_looked_up;
    logic                  o_second_hit;
    logic                  o_fill_done;
    logic [OUT_WAY_W-1:0]  o_fill_way;
    logic [OUT_LINE_W-1:0] o_fill_line_address;
    logic                  o_evicted_valid;

    // tag model
    bit                line_valid [ENTRIES];
    t_tag              line_tag   [ENTRIES];
    logic [LFSR_W-1:0] victim_lfsr;

    t_lookup_result pending_lookups [$];
    t_access_row    directed_rows   [$];
    logic [31:0]    address_history [$];
    bit             known_active;
    t_lookup_result known_result;
    int             error_count;
    int             stall_cycles;

    set_assoc_cache_tag_engine uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_address           (i_address),
        .i_length            (i_length),
        .o_valid             (o_valid),
        .o_first_hit         (o_first_hit),
        .o_first_way         (o_first_way),
        .o_crosses_line      (o_crosses_line),
        .o_second_looked_up  (o_second_looked_up),
        .o_second_hit        (o_second_hit),
        .o_fill_done         (o_fill_done),
        .o_fill_way          (o_fill_way),
        .o_fill_line_address (o_fill_line_address),
        .o_evicted_valid     (o_evicted_valid)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int find_way(logic [LINE_W-1:0] line);
        int set_idx;
        set_idx = int'(line[SET_W-1:0]);
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (line_valid[set_idx * WAY_COUNT + w] &&
                line_tag[set_idx * WAY_COUNT + w] == line[LINE_W-1:SET_W]) begin
                return w;
            end
        end
        return -1;
    endfunction

    function automatic void allocate_line(logic [LINE_W-1:0] line, inout t_lookup_result r);
        int   set_idx;
        int   way;
        bit   found;
        logic feedback;
        set_idx = int'(line[SET_W-1:0]);
        way     = 0;
        found   = 1'b0;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (!found && !line_valid[set_idx * WAY_COUNT + w]) begin
                way   = w;
                found = 1'b1;
            end
        end
        if (!found) begin
            // taps 16,14,13,11, shifting right
            feedback    = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
            victim_lfsr = {feedback, victim_lfsr[LFSR_W-1:1]};
            way         = int'(victim_lfsr % LFSR_W'(WAY_COUNT));
        end
        line_valid[set_idx * WAY_COUNT + way] = 1'b1;
        line_tag[set_idx * WAY_COUNT + way]   = line[LINE_W-1:SET_W];
        r.fill_done         = 1'b1;
        r.fill_way          = OUT_WAY_W'(way);
        r.fill_line_address = line;
        r.evicted_valid     = !found;
    endfunction

    function automatic t_lookup_result predict_lookup(bit mode, logic [31:0] address,
                                                      logic [2:0] length);
        t_lookup_result    r;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] next_line;
        int                reach;
        int                first;
        line      = address[ADDR_W-1:OFF_W];
        next_line = line + LINE_W'(1);
        reach     = int'(address[OFF_W-1:0]);
        reach     = reach + int'(length);
        first     = find_way(line);
        r                  = '0;
        r.first_hit        = first >= 0;
        r.first_way        = (first >= 0) ? OUT_WAY_W'(first) : '0;
        r.crosses_line     = reach > LINE_BYTES;
        if (mode == MODE_WRITE) begin
            // writes never touch the tags but still probe the next line when crossing
            if (r.crosses_line) begin
                r.second_looked_up = 1'b1;
                r.second_hit       = find_way(next_line) >= 0;
            end
        end else if (first >= 0) begin
            if (r.crosses_line) begin
                r.second_looked_up = 1'b1;
                if (find_way(next_line) >= 0) begin
                    r.second_hit = 1'b1;
                end else begin
                    allocate_line(next_line, r);
                end
            end
        end else begin
            allocate_line(line, r);
        end
        return r;
    endfunction

    function automatic t_lookup_result make_result(int fh, int fw, int cr, int sl, int sh,
                                                   int fd, int fwy, int fla, int ev);
        t_lookup_result r;
        r.first_hit         = 1'(fh);
        r.first_way         = OUT_WAY_W'(fw);
        r.crosses_line      = 1'(cr);
        r.second_looked_up  = 1'(sl);
        r.second_hit        = 1'(sh);
        r.fill_done         = 1'(fd);
        r.fill_way          = OUT_WAY_W'(fwy);
        r.fill_line_address = OUT_LINE_W'(fla);
        r.evicted_valid     = 1'(ev);
        return r;
    endfunction

    function automatic void add_row(bit mode, logic [31:0] address, logic [2:0] length,
                                    bit known, t_lookup_result result);
        t_access_row row;
        row.mode    = mode;
        row.address = address;
        row.length  = length;
        row.known   = known;
        row.result  = result;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_address();
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set_idx;
        logic [OFF_W-1:0] offset;
        logic [31:0]      a;
        int               sel;
        sel     = int'($urandom_range(99));
        tag     = TAG_W'($urandom_range(11));
        set_idx = SET_W'($urandom_range(3));
        offset  = OFF_W'($urandom);
        if ($urandom_range(9) == 0) begin
            tag = '1;
        end
        if (sel < 35 && address_history.size() > 0) begin
            a = address_history[$urandom_range(address_history.size() - 1)];
            a[OFF_W-1:0] = offset;
        end else if (sel < 65) begin
            // a few tags on a few sets keep the sets full
            a = {tag, set_idx, offset};
        end else if (sel < 85) begin
            offset = OFF_W'($urandom_range(LINE_BYTES - 8, LINE_BYTES - 1));
            a = {tag, set_idx, offset};
        end else begin
            a = $urandom;
        end
        return a;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            error_count++;
        end
    endtask

    // result beats are checked before the access of the same edge is predicted
    always @(posedge i_clk) begin : monitor
        t_lookup_result seen;
        t_lookup_result want;
        t_lookup_result predicted;
        bit             accepted;
        if (i_rst_n) begin
            accepted = start && busy === 1'b0;
            if (o_valid === 1'b1) begin
                seen.first_hit         = o_first_hit;
                seen.first_way         = o_first_way;
                seen.crosses_line      = o_crosses_line;
                seen.second_looked_up  = o_second_looked_up;
                seen.second_hit        = o_second_hit;
                seen.fill_done         = o_fill_done;
                seen.fill_way          = o_fill_way;
                seen.fill_line_address = o_fill_line_address;
                seen.evicted_valid     = o_evicted_valid;
                if (pending_lookups.size() == 0) begin
                    $display("%0t: result beat with none expected, actual %0h", $time, seen);
                    error_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("first_hit", 32'(want.first_hit), 32'(seen.first_hit));
                    check_field("first_way", 32'(want.first_way), 32'(seen.first_way));
                    check_field("crosses_line", 32'(want.crosses_line),
                                32'(seen.crosses_line));
                    check_field("second_looked_up", 32'(want.second_looked_up),
                                32'(seen.second_looked_up));
                    check_field("second_hit", 32'(want.second_hit), 32'(seen.second_hit));
                    check_field("fill_done", 32'(want.fill_done), 32'(seen.fill_done));
                    check_field("fill_way", 32'(want.fill_way), 32'(seen.fill_way));
                    check_field("fill_line_address", 32'(want.fill_line_address),
                                32'(seen.fill_line_address));
                    check_field("evicted_valid", 32'(want.evicted_valid),
                                32'(seen.evicted_valid));
                end
            end
            if (accepted) begin
                predicted = predict_lookup(i_mode, i_address, i_length);
                pending_lookups.push_back(known_active ? known_result : predicted);
            end
            stall_cycles = (accepted || o_valid === 1'b1) ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic issue_access(bit mode, logic [31:0] address, logic [2:0] length,
                                bit known, t_lookup_result result, int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_address    <= address;
        i_length     <= length;
        known_active <= known;
        known_result <= result;
        address_history.push_back(address);
        if (address_history.size() > HISTORY_MAX) begin
            void'(address_history.pop_front());
        end
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_lookups.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          idle_plan [4];
        int          idle_pct;
        bit          mode;
        logic [31:0] address;
        logic [2:0]  length;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = MODE_READ;
        i_address    = '0;
        i_length     = '0;
        known_active = 1'b0;
        known_result = '0;
        error_count  = 0;
        stall_cycles = 0;
        victim_lfsr  = LFSR_RESET;
        foreach (line_valid[e]) begin
            line_valid[e] = 1'b0;
            line_tag[e]   = '0;
        end

        add_row(MODE_READ,  32'h0000_0000, 3'd1, 1'b1, make_result(0,0,0,0,0,1,0,0,0));
        add_row(MODE_READ,  32'h0000_0000, 3'd4, 1'b1, make_result(1,0,0,0,0,0,0,0,0));
        add_row(MODE_READ,  32'h0000_003F, 3'd1, 1'b1, make_result(1,0,0,0,0,0,0,0,0));
        add_row(MODE_READ,  32'h0000_003F, 3'd2, 1'b1, make_result(1,0,1,1,0,1,0,1,0));
        add_row(MODE_READ,  32'hFFFF_FFFF, 3'd1, 1'b1,
                make_result(0,0,0,0,0,1,0,26'h3FF_FFFF,0));
        // last line wraps round to line zero
        add_row(MODE_READ,  32'hFFFF_FFFF, 3'd4, 1'b1, make_result(1,0,1,1,1,0,0,0,0));
        add_row(MODE_WRITE, 32'h1234_5678, 3'd2, 1'b1, make_result(0,0,0,0,0,0,0,0,0));
        // crossing write that misses both lines
        add_row(MODE_WRITE, 32'h1000_003E, 3'd4, 1'b1, make_result(0,0,1,1,0,0,0,0,0));
        add_row(MODE_WRITE, 32'h0000_003F, 3'd2, 1'b1, make_result(1,0,1,1,1,0,0,0,0));
        add_row(MODE_READ,  32'h0000_0000, 3'd0, 1'b1, make_result(1,0,0,0,0,0,0,0,0));
        add_row(MODE_READ,  32'h0000_007A, 3'd7, 1'b1, make_result(1,0,1,1,0,1,0,2,0));
        // crossing read miss fills the first line only
        add_row(MODE_READ,  32'h1000_007F, 3'd4, 1'b1,
                make_result(0,0,1,0,0,1,1,26'h40_0001,0));
        // nine tags on one set: the last one evicts
        for (int t = 1; t <= WAY_COUNT + 1; t++) begin
            add_row(MODE_READ, (t << (SET_W + OFF_W)) | (5 << OFF_W), 3'd3, 1'b0, '0);
        end
        add_row(MODE_READ,  (1 << (SET_W + OFF_W)) | (5 << OFF_W), 3'd1, 1'b0, '0);
        add_row(MODE_WRITE, 32'h0000_003C, 3'd5, 1'b0, '0);
        add_row(MODE_READ,  32'hFFFF_FFFC, 3'd6, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            issue_access(directed_rows[r].mode, directed_rows[r].address,
                         directed_rows[r].length, directed_rows[r].known,
                         directed_rows[r].result, 0);
        end
        wait_drained();

        // last phase mixes the idle rates beat by beat
        idle_plan = '{0, 87, 33, -1};
        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_pct = idle_plan[p];
                if (idle_pct < 0) begin
                    case ($urandom_range(2))
                        0: idle_pct = 0;
                        1: idle_pct = 33;
                        default: idle_pct = 87;
                    endcase
                end
                mode    = ($urandom_range(99) < 30) ? MODE_WRITE : MODE_READ;
                address = pick_address();
                length  = ($urandom_range(99) < 8) ? LEN_W'($urandom_range(7))
                                                   : LEN_W'($urandom_range(1, 4));
                issue_access(mode, address, length, 1'b0, '0, idle_pct);
                if ($urandom_range(99) == 0) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
